@@ sv/fpa_pkg.sv @@
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Operation codes and the side payload that travels along the pipeline.
// ----------------------------------------------------------------------------
package fpa_pkg;

    typedef enum logic [3:0] {
        ACT_ADD        = 4'd0,
        ACT_SUB        = 4'd1,
        ACT_MUL        = 4'd2,
        ACT_DIV        = 4'd3,
        ACT_COMPARE    = 4'd4,
        ACT_MIN        = 4'd5,
        ACT_MAX        = 4'd6,
        ACT_INC        = 4'd7,
        ACT_DEC        = 4'd8,
        ACT_INT_TO_FIX = 4'd9,
        ACT_FIX_TO_INT = 4'd10
    } t_action;

    // Result and flags of one request, carried beside the divider state
    typedef struct packed {
        logic [31:0] result;
        logic        gt;
        logic        lt;
        logic        eq;
        logic        ovf;
        logic        is_div;
        logic        neg;
        logic        dbz;
    } t_side;

endpackage

@@ sv/fixed_point_q24_8_alu.sv @@
// ----------------------------------------------------------------------------
// Fixed-point Q24.8 ALU
// Signed 32-bit fixed-point arithmetic, compare and conversion unit.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_in_valid / o_in_ready carries i_action, i_operand_a and
//   i_operand_b; output channel o_out_valid / i_out_ready returns o_result,
//   the three comparison flags, o_overflow and o_divide_by_zero.
//   Every request yields exactly one result, in request order.
//   The path from acceptance to o_out_valid runs through two front stages,
//   one divider cell per quotient bit, 32 + FRAC_BITS cells, and the
//   output register. Every operation runs the same path.
//   Throughput is one request per cycle while the skid register is empty;
//   the divider cell chain is fully pipelined and makes up most of the path.
//   When the receiver stalls, a skid register catches the result in flight;
//   o_in_ready drops only while the skid register is full, and the whole
//   pipeline holds until the output drains.
//   Reset clears all valid bits; no request is in flight afterwards.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu #(
    parameter int FRAC_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [3:0]         i_action,
    input  logic signed [31:0] i_operand_a,
    input  logic signed [31:0] i_operand_b,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_result,
    output logic               o_a_greater,
    output logic               o_a_less,
    output logic               o_a_equal,
    output logic               o_overflow,
    output logic               o_divide_by_zero
);

    localparam int NQ = 32 + FRAC_BITS;

    logic                n_en;
    logic                w_valid [0:NQ];
    logic [31:0]         w_rem   [0:NQ];
    logic [NQ-1:0]       w_w     [0:NQ];
    logic [31:0]         w_d     [0:NQ];
    fpa_pkg::t_side      w_side  [0:NQ];

    fpa_pkg::t_side      n_fin;
    logic [NQ-1:0]       n_q;
    logic                n_q_fit;

    logic                r_out_v;
    fpa_pkg::t_side      r_out;
    logic                r_skid_v;
    fpa_pkg::t_side      r_skid;

    assign n_en       = !r_skid_v;
    assign o_in_ready = n_en;

    fpa_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (n_en),
        .i_valid     (i_in_valid),
        .i_action    (i_action),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_valid     (w_valid[0]),
        .o_w         (w_w[0]),
        .o_d         (w_d[0]),
        .o_side      (w_side[0])
    );

    assign w_rem[0] = '0;

    for (genvar g = 0; g < NQ; g++) begin : g_cell
        fpa_div_cell #(
            .NQ (NQ)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (n_en),
            .i_valid (w_valid[g]),
            .i_rem   (w_rem[g]),
            .i_w     (w_w[g]),
            .i_d     (w_d[g]),
            .i_side  (w_side[g]),
            .o_valid (w_valid[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_w     (w_w[g+1]),
            .o_d     (w_d[g+1]),
            .o_side  (w_side[g+1])
        );
    end

    // Sign the quotient and check it against the 32-bit range
    always_comb begin
        n_q   = w_w[NQ];
        n_fin = w_side[NQ];
        if (w_side[NQ].neg) begin
            n_q_fit = !(|n_q[NQ-1:31]) ||
                      (!(|n_q[NQ-1:32]) && (n_q[31:0] == 32'h8000_0000));
        end else begin
            n_q_fit = !(|n_q[NQ-1:31]);
        end
        if (w_side[NQ].is_div) begin
            if (w_side[NQ].dbz) begin
                n_fin.result = '0;
                n_fin.ovf    = 1'b0;
            end else begin
                n_fin.result = w_side[NQ].neg ? 32'(-n_q[31:0]) : n_q[31:0];
                n_fin.ovf    = !n_q_fit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || i_out_ready) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v  <= w_valid[NQ];
            end
        end else if (w_valid[NQ] && n_en) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || i_out_ready) begin
            r_out <= r_skid_v ? r_skid : n_fin;
        end else if (n_en) begin
            r_skid <= n_fin;
        end
    end

    assign o_out_valid      = r_out_v;
    assign o_result         = r_out.result;
    assign o_a_greater      = r_out.gt;
    assign o_a_less         = r_out.lt;
    assign o_a_equal        = r_out.eq;
    assign o_overflow       = r_out.ovf;
    assign o_divide_by_zero = r_out.dbz;

    // Skid register is only ever filled behind a held output
    a_skid_behind_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid register full with empty output register");

    a_one_relation : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot({o_a_greater, o_a_less, o_a_equal}))
        else $error("comparison flags not one-hot");

    a_dbz_clean : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_divide_by_zero) |-> (o_result == 32'sd0 && !o_overflow))
        else $error("divide by zero result not cleared");

endmodule

@@ sv/fpa_div_cell.sv @@
// ----------------------------------------------------------------------------
// Divider cell
// One restoring step: produces one quotient bit and passes the partial
// remainder, the shifting dividend/quotient word and the side payload on.
// ----------------------------------------------------------------------------
module fpa_div_cell #(
    parameter int NQ = 40
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [31:0]          i_rem,
    input  logic [NQ-1:0]        i_w,
    input  logic [31:0]          i_d,
    input  fpa_pkg::t_side       i_side,
    output logic                 o_valid,
    output logic [31:0]          o_rem,
    output logic [NQ-1:0]        o_w,
    output logic [31:0]          o_d,
    output fpa_pkg::t_side       o_side
);

    logic [32:0] n_trial;
    logic        n_ge;
    logic [32:0] n_diff;

    logic                r_valid;
    logic [31:0]         r_rem;
    logic [NQ-1:0]       r_w;
    logic [31:0]         r_d;
    fpa_pkg::t_side      r_side;

    always_comb begin
        n_trial = {i_rem, i_w[NQ-1]};
        n_ge    = (n_trial >= {1'b0, i_d});
        n_diff  = n_trial - {1'b0, i_d};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_ge ? n_diff[31:0] : n_trial[31:0];
            r_w    <= {i_w[NQ-2:0], n_ge};
            r_d    <= i_d;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_w     = r_w;
    assign o_d     = r_d;
    assign o_side  = r_side;

endmodule

@@ sv/fpa_front.sv @@
// ----------------------------------------------------------------------------
// ALU front end
// Registers the request, evaluates all non-divide operations and the
// comparator, forms the product, then rounds it and prepares the divider.
// ----------------------------------------------------------------------------
module fpa_front #(
    parameter int FRAC_BITS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [3:0]                  i_action,
    input  logic signed [31:0]          i_operand_a,
    input  logic signed [31:0]          i_operand_b,
    output logic                        o_valid,
    output logic [32+FRAC_BITS-1:0]     o_w,
    output logic [31:0]                 o_d,
    output fpa_pkg::t_side              o_side
);

    localparam int NQ = 32 + FRAC_BITS;
    localparam logic [63:0] HALF = 64'(1) << (FRAC_BITS - 1);

    logic               r_s0_v;
    logic [3:0]         r_s0_act;
    logic signed [31:0] r_s0_a;
    logic signed [31:0] r_s0_b;

    logic               r_s1_v;
    logic               r_s1_is_mul;
    logic signed [63:0] r_s1_prod;
    logic [NQ-1:0]      r_s1_w;
    logic [31:0]        r_s1_d;
    fpa_pkg::t_side     r_s1_side;

    logic signed [32:0] n_add;
    logic signed [32:0] n_sub;
    logic signed [32:0] n_inc;
    logic signed [32:0] n_dec;
    logic [NQ-1:0]      n_i2f;
    logic signed [63:0] n_prod;
    logic [31:0]        n_abs_a;
    logic [31:0]        n_abs_b;
    fpa_pkg::t_side     n_side;
    logic signed [63:0] n_rnd;
    logic               n_is_mul;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
            r_s1_v <= 1'b0;
        end else if (i_en) begin
            r_s0_v <= i_valid;
            r_s1_v <= r_s0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s0_act <= i_action;
            r_s0_a   <= i_operand_a;
            r_s0_b   <= i_operand_b;
        end
    end

    always_comb begin
        n_add   = {r_s0_a[31], r_s0_a} + {r_s0_b[31], r_s0_b};
        n_sub   = {r_s0_a[31], r_s0_a} - {r_s0_b[31], r_s0_b};
        n_inc   = {r_s0_a[31], r_s0_a} + 33'sd1;
        n_dec   = {r_s0_a[31], r_s0_a} - 33'sd1;
        n_i2f   = {{FRAC_BITS{r_s0_a[31]}}, r_s0_a} << FRAC_BITS;
        n_prod  = r_s0_a * r_s0_b;
        n_abs_a = r_s0_a[31] ? 32'(-r_s0_a) : r_s0_a;
        n_abs_b = r_s0_b[31] ? 32'(-r_s0_b) : r_s0_b;
        n_is_mul = 1'b0;

        n_side        = '0;
        n_side.gt     = (r_s0_a > r_s0_b);
        n_side.lt     = (r_s0_a < r_s0_b);
        n_side.eq     = (r_s0_a == r_s0_b);
        n_side.neg    = r_s0_a[31] ^ r_s0_b[31];

        unique case (fpa_pkg::t_action'(r_s0_act))
            fpa_pkg::ACT_ADD: begin
                n_side.result = n_add[31:0];
                n_side.ovf    = n_add[32] != n_add[31];
            end
            fpa_pkg::ACT_SUB: begin
                n_side.result = n_sub[31:0];
                n_side.ovf    = n_sub[32] != n_sub[31];
            end
            fpa_pkg::ACT_MUL: begin
                n_is_mul = 1'b1;
            end
            fpa_pkg::ACT_DIV: begin
                n_side.is_div = 1'b1;
                n_side.dbz    = (r_s0_b == 32'sd0);
            end
            fpa_pkg::ACT_COMPARE: begin
                n_side.result = '0;
            end
            fpa_pkg::ACT_MIN: begin
                n_side.result = (r_s0_a < r_s0_b) ? r_s0_a : r_s0_b;
            end
            fpa_pkg::ACT_MAX: begin
                n_side.result = (r_s0_a > r_s0_b) ? r_s0_a : r_s0_b;
            end
            fpa_pkg::ACT_INC: begin
                n_side.result = n_inc[31:0];
                n_side.ovf    = n_inc[32] != n_inc[31];
            end
            fpa_pkg::ACT_DEC: begin
                n_side.result = n_dec[31:0];
                n_side.ovf    = n_dec[32] != n_dec[31];
            end
            fpa_pkg::ACT_INT_TO_FIX: begin
                n_side.result = n_i2f[31:0];
                n_side.ovf    = !((&n_i2f[NQ-1:31]) || !(|n_i2f[NQ-1:31]));
            end
            fpa_pkg::ACT_FIX_TO_INT: begin
                n_side.result = 32'(r_s0_a >>> FRAC_BITS);
            end
            default: begin
                n_side.result = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_is_mul <= n_is_mul;
            r_s1_prod   <= n_prod;
            r_s1_w      <= {n_abs_a, {FRAC_BITS{1'b0}}};
            r_s1_d      <= n_abs_b;
            r_s1_side   <= n_side;
        end
    end

    // Round half away from zero: bias by one less than half on negative products
    always_comb begin
        n_rnd = (r_s1_prod + (r_s1_prod[63] ? $signed(HALF - 64'd1) : $signed(HALF)))
                >>> FRAC_BITS;
        o_side = r_s1_side;
        if (r_s1_is_mul) begin
            o_side.result = n_rnd[31:0];
            o_side.ovf    = !((&n_rnd[63:31]) || !(|n_rnd[63:31]));
        end
    end

    assign o_valid = r_s1_v;
    assign o_w     = r_s1_w;
    assign o_d     = r_s1_d;

endmodule

@@ bench/fixed_point_q24_8_alu_tb.sv @@
// ----------------------------------------------------------------------------
// Fixed-point Q24.8 ALU testbench
// Sends directed and random requests through the valid/ready input channel,
// predicts every result with an independent Q24.8 arithmetic model and checks
// each returned result and its flags in order. Both channels idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fixed_point_q24_8_alu_tb;

    localparam int FRAC       = 8;
    localparam int N_RANDOM   = 650;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = FRAC + 60;
    localparam logic [3:0] ACT_UNDEF_LO = 4'd11;
    localparam logic [3:0] ACT_UNDEF_HI = 4'd15;

    typedef struct packed {
        logic [3:0]         action;
        logic signed [31:0] a;
        logic signed [31:0] b;
    } t_request;

    typedef struct packed {
        logic signed [31:0] result;
        logic               gt;
        logic               lt;
        logic               eq;
        logic               ovf;
        logic               dbz;
    } t_outcome;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [3:0]         i_action;
    logic signed [31:0] i_operand_a;
    logic signed [31:0] i_operand_b;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [31:0] o_result;
    logic               o_a_greater;
    logic               o_a_less;
    logic               o_a_equal;
    logic               o_overflow;
    logic               o_divide_by_zero;

    // handshake seen at the last rising edge
    logic o_in_ready_s;
    logic o_out_valid_s;

    t_request pending_q[$];
    t_outcome expected_q[$];
    int       n_errors;
    int       n_sent;
    int       n_checked;
    int       idle_cycles;
    bit       stim_done;
    int       send_wait;
    int       take_wait;

    fixed_point_q24_8_alu #(.FRAC_BITS(FRAC)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (i_action),
        .i_operand_a     (i_operand_a),
        .i_operand_b     (i_operand_b),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_result        (o_result),
        .o_a_greater     (o_a_greater),
        .o_a_less        (o_a_less),
        .o_a_equal       (o_a_equal),
        .o_overflow      (o_overflow),
        .o_divide_by_zero(o_divide_by_zero)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic t_outcome alu_predict(t_request rq);
        t_outcome    o;
        longint      a;
        longint      b;
        longint      r;
        longint      p;
        longint      m;
        bit          chk;
        a   = longint'(rq.a);
        b   = longint'(rq.b);
        r   = 0;
        chk = 1'b1;
        o   = '0;
        case (rq.action)
            fpa_pkg::ACT_ADD: r = a + b;
            fpa_pkg::ACT_SUB: r = a - b;
            fpa_pkg::ACT_MUL: begin
                p = a * b;
                m = (p < 0) ? -p : p;
                m = (m + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
                r = (p < 0) ? -m : m;
            end
            fpa_pkg::ACT_DIV: begin
                if (b == 0) o.dbz = 1'b1;
                else        r = (a * (64'sd1 <<< FRAC)) / b;
            end
            fpa_pkg::ACT_COMPARE:    r = 0;
            fpa_pkg::ACT_MIN:        r = (a < b) ? a : b;
            fpa_pkg::ACT_MAX:        r = (a > b) ? a : b;
            fpa_pkg::ACT_INC:        r = a + 1;
            fpa_pkg::ACT_DEC:        r = a - 1;
            fpa_pkg::ACT_INT_TO_FIX: r = a * (64'sd1 <<< FRAC);
            fpa_pkg::ACT_FIX_TO_INT: r = a >>> FRAC;
            default: chk = 1'b0;
        endcase
        o.result = r[31:0];
        o.gt     = a > b;
        o.lt     = a < b;
        o.eq     = a == b;
        o.ovf    = chk && (r < -64'sd2147483648 || r > 64'sd2147483647);
        return o;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        n_errors++;
        $display("MISMATCH %s: got %0d expected %0d (result #%0d)",
                 what, got, want, n_checked);
    endtask

    function automatic logic signed [31:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            1: return $signed(32'($urandom_range(0, 1024))) - 512;
            2: return $signed(32'($urandom_range(0, 1 << 16))) - (1 << 15);
            3: return 32'(($urandom_range(0, 64) - 32)) <<< FRAC;
            default: return $signed($urandom());
        endcase
    endfunction

    task automatic push_req(logic [3:0] act, logic signed [31:0] a,
                            logic signed [31:0] b);
        pending_q.push_back('{action: act, a: a, b: b});
    endtask

    initial begin
        logic [3:0] act;
        logic signed [31:0] a;
        logic signed [31:0] b;
        n_errors  = 0;
        n_sent    = 0;
        n_checked = 0;
        stim_done = 1'b0;
        // directed: extremes, every operation, special cases
        push_req(fpa_pkg::ACT_ADD, 32'sh7fffffff, 32'sd1);
        push_req(fpa_pkg::ACT_SUB, 32'sh80000000, 32'sd1);
        push_req(fpa_pkg::ACT_MUL, 32'sh80000000, 32'sh80000000);
        push_req(fpa_pkg::ACT_MUL, 32'sd384, -32'sd1);
        push_req(fpa_pkg::ACT_MUL, 32'sd128, 32'sd1);
        push_req(fpa_pkg::ACT_MUL, -32'sd128, 32'sd1);
        push_req(fpa_pkg::ACT_DIV, 32'sd1000, 32'sd0);
        push_req(fpa_pkg::ACT_DIV, 32'sh80000000, -32'sd1);
        push_req(fpa_pkg::ACT_DIV, -32'sd7, 32'sd3);
        push_req(fpa_pkg::ACT_COMPARE, 32'sh7fffffff, 32'sh80000000);
        push_req(fpa_pkg::ACT_COMPARE, 32'sd5, 32'sd5);
        push_req(fpa_pkg::ACT_MIN, 32'sd9, 32'sd9);
        push_req(fpa_pkg::ACT_MIN, -32'sd3, 32'sd4);
        push_req(fpa_pkg::ACT_MAX, 32'sh80000000, 32'sh7fffffff);
        push_req(fpa_pkg::ACT_INC, 32'sh7fffffff, 32'sd0);
        push_req(fpa_pkg::ACT_DEC, 32'sh80000000, 32'sd0);
        push_req(fpa_pkg::ACT_INT_TO_FIX, 32'sh00800000, 32'sd0);
        push_req(fpa_pkg::ACT_INT_TO_FIX, -32'sd1, 32'sd0);
        push_req(fpa_pkg::ACT_FIX_TO_INT, -32'sd1, 32'sd0);
        push_req(fpa_pkg::ACT_FIX_TO_INT, 32'sh80000000, 32'shffffffff);
        push_req(ACT_UNDEF_LO, 32'sd1, 32'sd2);
        push_req(ACT_UNDEF_HI, 32'sh7fffffff, -32'sd1);
        for (int i = 0; i < N_RANDOM; i++) begin
            act = (i % 20 == 0) ? 4'($urandom_range(ACT_UNDEF_LO, ACT_UNDEF_HI))
                                : 4'($urandom_range(fpa_pkg::ACT_ADD,
                                                    fpa_pkg::ACT_FIX_TO_INT));
            a = rand_operand();
            b = ($urandom_range(0, 9) == 0) ? a
              : ($urandom_range(0, 12) == 0) ? 32'sd0 : rand_operand();
            push_req(act, a, b);
        end
        stim_done = 1'b1;
    end

    // driver: inputs change on the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_action    <= '0;
            i_operand_a <= '0;
            i_operand_b <= '0;
            i_out_ready <= 1'b0;
            send_wait   <= $urandom_range(0, 7);
            take_wait   <= 0;
        end else begin
            if (!i_in_valid || o_in_ready_s) begin
                if (send_wait > 0) begin
                    i_in_valid <= 1'b0;
                    send_wait  <= send_wait - 1;
                end else if (pending_q.size() > 0) begin
                    i_in_valid  <= 1'b1;
                    i_action    <= pending_q[0].action;
                    i_operand_a <= pending_q[0].a;
                    i_operand_b <= pending_q[0].b;
                    void'(pending_q.pop_front());
                    // stretches with no gaps
                    send_wait   <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : 0;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            if (take_wait > 0) begin
                i_out_ready <= 1'b0;
                take_wait   <= take_wait - 1;
            end else begin
                i_out_ready <= 1'b1;
                if (o_out_valid_s)
                    take_wait <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 7) : 0;
            end
        end
    end

    // monitor: sample at the rising edge
    always @(posedge i_clk) begin
        t_outcome want;
        o_in_ready_s  <= i_in_valid && o_in_ready;
        o_out_valid_s <= o_out_valid && i_out_ready;
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_q.push_back(alu_predict('{action: i_action, a: i_operand_a,
                                                   b: i_operand_b}));
                n_sent++;
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result", o_result, 0);
                end else begin
                    want = expected_q.pop_front();
                    if (o_result !== want.result)
                        report_mismatch("result", o_result, want.result);
                    if (o_a_greater !== want.gt)
                        report_mismatch("a_greater", o_a_greater, want.gt);
                    if (o_a_less !== want.lt)
                        report_mismatch("a_less", o_a_less, want.lt);
                    if (o_a_equal !== want.eq)
                        report_mismatch("a_equal", o_a_equal, want.eq);
                    if (o_overflow !== want.ovf)
                        report_mismatch("overflow", o_overflow, want.ovf);
                    if (o_divide_by_zero !== want.dbz)
                        report_mismatch("divide_by_zero", o_divide_by_zero, want.dbz);
                end
                n_checked++;
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Watchdog: no handshake for %0d cycles", STALL_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_action      = '0;
        i_operand_a   = '0;
        i_operand_b   = '0;
        i_out_ready   = 1'b0;
        o_in_ready_s  = 1'b0;
        o_out_valid_s = 1'b0;
        idle_cycles   = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        wait (stim_done && pending_q.size() == 0);
        @(posedge i_clk iff !i_in_valid);
        wait (expected_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_q.size() != 0)
            report_mismatch("results left over", expected_q.size(), 0);
        $display("Covered %0d requests over all eleven operations and undefined codes,",
                 n_sent);
        $display("with %0d results checked under random gaps on both channels.", n_checked);
        if (n_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ sim.f @@
sv/fpa_pkg.sv
sv/fpa_div_cell.sv
sv/fpa_front.sv
sv/fixed_point_q24_8_alu.sv
bench/fixed_point_q24_8_alu_tb.sv
